/* rtl/vru_pkg.sv */
package vru_pkg;

   // element and fixed-point format
   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_WIDTH = 2 * ELEM_WIDTH;

   // accumulator format, signed Q32.32
   localparam int ACC_WIDTH = 64;
   localparam int Q_FRAC    = 32;

   localparam logic [ACC_WIDTH-1:0] SIGN64 = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic [ACC_WIDTH-1:0] MAXPOS = {1'b0, {(ACC_WIDTH-1){1'b1}}};

   // register port
   localparam int MODE_WIDTH      = 3;
   localparam int TOL_WIDTH       = 31;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE = 2'd1;

   // reduction modes
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_DOT    = 3'd0,
      MODE_SQDIST = 3'd1,
      MODE_SUM    = 3'd2,
      MODE_MIN    = 3'd3,
      MODE_MAX    = 3'd4,
      MODE_EQUAL  = 3'd5
   } mode_type;

   // one scaled term on its way to the accumulator
   typedef struct packed {
      logic [ACC_WIDTH-1:0] value;
      logic                 ovf;
      logic                 close_fail;
      logic                 last;
   } term_type;

   typedef struct packed {
      logic                 ovf;
      logic [ACC_WIDTH-1:0] value;
   } q32_type;

   // scale a signed magnitude with frac fraction bits to Q32.32, saturating
   function automatic q32_type to_q32(input logic [ACC_WIDTH-1:0] mag, input logic neg,
                                      input int unsigned frac);
      logic [ACC_WIDTH-1:0] m;
      logic [ACC_WIDTH-1:0] lim;
      int unsigned          lsh;
      q32_type              res;
      m   = mag;
      lsh = 0;
      lim = neg ? SIGN64 : MAXPOS;
      if (frac > Q_FRAC) begin
         m = mag >> (frac - Q_FRAC);
      end else begin
         lsh = Q_FRAC - frac;
      end
      if (m > (lim >> lsh)) begin
         res.ovf   = 1'b1;
         res.value = lim;
      end else begin
         m         = m << lsh;
         res.ovf   = 1'b0;
         res.value = neg ? ({ACC_WIDTH{1'b0}} - m) : m;
      end
      return res;
   endfunction

endpackage

/* rtl/vru_term.sv */
module vru_term import vru_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [31:0]    elem_a,
   input  logic signed [31:0]    elem_b,
   input  logic                  last,
   input  logic [MODE_WIDTH-1:0] mode,
   input  logic [TOL_WIDTH-1:0]  tolerance,
   output logic                  out_valid,
   input  logic                  out_ready,
   output term_type              out_term
);

   // input register
   logic                  s1_valid_ff;
   logic [ELEM_WIDTH-1:0] s1_a_ff;
   logic [ELEM_WIDTH-1:0] s1_b_ff;
   logic                  s1_last_ff;

   // product register
   logic                  s2_valid_ff;
   logic [PROD_WIDTH-1:0] s2_prod_ff;
   logic                  s2_prod_neg_ff;
   logic [ELEM_WIDTH-1:0] s2_ma_ff;
   logic                  s2_na_ff;
   logic                  s2_close_fail_ff;
   logic                  s2_last_ff;

   // term register
   logic                  s3_valid_ff;
   term_type              s3_term_ff;

   logic s1_ready;
   logic s2_ready;
   logic s3_ready;

   logic [ELEM_WIDTH-1:0] ma_in;
   logic [ELEM_WIDTH-1:0] mb_in;
   logic                  na_in;
   logic                  nb_in;
   logic [ELEM_WIDTH:0]   diff;
   logic [ELEM_WIDTH:0]   diff_abs;
   logic [ELEM_WIDTH-1:0] d_in;
   logic [ELEM_WIDTH-1:0] op_x;
   logic [ELEM_WIDTH-1:0] op_y;
   logic [PROD_WIDTH-1:0] prod_in;
   logic                  prod_neg_in;
   logic                  close_fail_in;
   q32_type               q_prod;
   q32_type               q_elem;
   term_type              term_in;

   // stall chain, each stage moves when the one after it has room
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // magnitudes, difference and multiplier operands
   always_comb begin
      na_in    = s1_a_ff[ELEM_WIDTH-1];
      nb_in    = s1_b_ff[ELEM_WIDTH-1];
      ma_in    = na_in ? (~s1_a_ff + 1'b1) : s1_a_ff;
      mb_in    = nb_in ? (~s1_b_ff + 1'b1) : s1_b_ff;
      diff     = {s1_b_ff[ELEM_WIDTH-1], s1_b_ff} - {s1_a_ff[ELEM_WIDTH-1], s1_a_ff};
      diff_abs = diff[ELEM_WIDTH] ? ({(ELEM_WIDTH+1){1'b0}} - diff) : diff;
      d_in     = diff_abs[ELEM_WIDTH-1:0];
      close_fail_in = ACC_WIDTH'(d_in) > ACC_WIDTH'(tolerance);
      if (mode == MODE_SQDIST) begin
         op_x        = d_in;
         op_y        = d_in;
         prod_neg_in = 1'b0;
      end else begin
         op_x        = ma_in;
         op_y        = mb_in;
         prod_neg_in = na_in ^ nb_in;
      end
      prod_in = PROD_WIDTH'(op_x) * PROD_WIDTH'(op_y);
   end

   // scaling to Q32.32
   always_comb begin
      q_prod = to_q32(ACC_WIDTH'(s2_prod_ff), s2_prod_neg_ff, 2 * FRAC_BITS);
      q_elem = to_q32(ACC_WIDTH'(s2_ma_ff), s2_na_ff, FRAC_BITS);
      if (mode == MODE_DOT || mode == MODE_SQDIST) begin
         term_in.value = q_prod.value;
         term_in.ovf   = q_prod.ovf;
      end else begin
         term_in.value = q_elem.value;
         term_in.ovf   = q_elem.ovf;
      end
      term_in.close_fail = s2_close_fail_ff;
      term_in.last       = s2_last_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_a_ff    <= elem_a[ELEM_WIDTH-1:0];
         s1_b_ff    <= elem_b[ELEM_WIDTH-1:0];
         s1_last_ff <= last;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_prod_ff       <= prod_in;
         s2_prod_neg_ff   <= prod_neg_in;
         s2_ma_ff         <= ma_in;
         s2_na_ff         <= na_in;
         s2_close_fail_ff <= close_fail_in;
         s2_last_ff       <= s1_last_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_term_ff <= term_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_term  = s3_term_ff;

endmodule

/* rtl/vru_accum.sv */
module vru_accum import vru_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  term_valid,
   output logic                  term_ready,
   input  term_type              term,
   input  logic [MODE_WIDTH-1:0] mode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ACC_WIDTH-1:0]  rsp_value,
   output logic                  rsp_all_close,
   output logic                  rsp_overflowed
);

   logic [ACC_WIDTH-1:0] acc_ff;
   logic                 close_ff;
   logic                 first_ff;
   logic                 ovf_ff;
   logic                 rsp_valid_ff;
   logic [ACC_WIDTH-1:0] rsp_value_ff;
   logic                 rsp_all_close_ff;
   logic                 rsp_overflowed_ff;

   logic [ACC_WIDTH-1:0] acc_in;
   logic                 close_in;
   logic                 ovf_in;
   logic [ACC_WIDTH-1:0] rsp_value_in;
   logic                 rsp_all_close_in;
   logic                 rsp_overflowed_in;

   logic [ACC_WIDTH-1:0] base;
   logic [ACC_WIDTH-1:0] sum;
   logic                 add_ovf;
   logic                 term_lt_acc;
   logic                 acc_lt_term;
   logic                 fire;

   // a closing term needs the result register free, others always go
   assign term_ready = !term.last || !rsp_valid_ff || rsp_ready;
   assign fire       = term_valid && term_ready;

   // saturating add and signed compares
   always_comb begin
      base        = first_ff ? {ACC_WIDTH{1'b0}} : acc_ff;
      sum         = base + term.value;
      add_ovf     = (base[ACC_WIDTH-1] == term.value[ACC_WIDTH-1]) &&
                    (sum[ACC_WIDTH-1] != base[ACC_WIDTH-1]);
      term_lt_acc = $signed(term.value) < $signed(acc_ff);
      acc_lt_term = $signed(acc_ff) < $signed(term.value);
   end

   // next accumulator state by mode
   always_comb begin
      acc_in   = acc_ff;
      close_in = close_ff;
      ovf_in   = ovf_ff;
      case (mode) inside
         MODE_DOT, MODE_SQDIST, MODE_SUM: begin
            acc_in = add_ovf ? (base[ACC_WIDTH-1] ? SIGN64 : MAXPOS) : sum;
            ovf_in = ovf_ff | term.ovf | add_ovf;
         end
         MODE_MIN: begin
            if (first_ff || term_lt_acc) begin
               acc_in = term.value;
            end
            ovf_in = ovf_ff | term.ovf;
         end
         MODE_MAX: begin
            if (first_ff || acc_lt_term) begin
               acc_in = term.value;
            end
            ovf_in = ovf_ff | term.ovf;
         end
         MODE_EQUAL: begin
            if (term.close_fail) begin
               close_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // result fields
   always_comb begin
      case (mode) inside
         MODE_DOT, MODE_SQDIST, MODE_SUM, MODE_MIN, MODE_MAX: begin
            rsp_value_in      = acc_in;
            rsp_all_close_in  = 1'b0;
            rsp_overflowed_in = ovf_in;
         end
         MODE_EQUAL: begin
            rsp_value_in      = {ACC_WIDTH{1'b0}};
            rsp_all_close_in  = close_in;
            rsp_overflowed_in = ovf_in;
         end
         default: begin
            rsp_value_in      = {ACC_WIDTH{1'b0}};
            rsp_all_close_in  = 1'b0;
            rsp_overflowed_in = 1'b0;
         end
      endcase
   end

   // accumulator state, cleared after each vector
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= {ACC_WIDTH{1'b0}};
         close_ff <= 1'b1;
         first_ff <= 1'b1;
         ovf_ff   <= 1'b0;
      end else if (fire) begin
         if (term.last) begin
            acc_ff   <= {ACC_WIDTH{1'b0}};
            close_ff <= 1'b1;
            first_ff <= 1'b1;
            ovf_ff   <= 1'b0;
         end else begin
            acc_ff   <= acc_in;
            close_ff <= close_in;
            first_ff <= 1'b0;
            ovf_ff   <= ovf_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && term.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && term.last) begin
         rsp_value_ff      <= rsp_value_in;
         rsp_all_close_ff  <= rsp_all_close_in;
         rsp_overflowed_ff <= rsp_overflowed_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_all_close  = rsp_all_close_ff;
   assign rsp_overflowed = rsp_overflowed_ff;

   // closing term always leaves a result behind
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (fire && term.last) |=> rsp_valid_ff)
      else $error("closing term produced no result");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (fire && term.last) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

   // state is back to its cleared values after a vector ends
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (fire && term.last) |=> (first_ff && close_ff && !ovf_ff && acc_ff == '0))
      else $error("state not cleared after vector");

   // a nonzero value never comes with the equality verdict
   a_value_xor_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_value_ff != '0) |-> !rsp_all_close_ff)
      else $error("value and all_close both set");

endmodule

/* rtl/vector_reduction_unit_top.sv */
// vector reduction unit
// req channel: one element pair per transfer (req_elem_a, req_elem_b, signed
// Q16.16) with req_last_element marking the final pair of a vector.
// rsp channel: one transfer per vector, after its last pair: rsp_value in
// signed Q32.32, rsp_all_close (equality mode) and rsp_overflowed.
// csr channel: index 0 mode (0 dot, 1 squared distance, 2 sum, 3 min, 4 max,
// 5 equality), index 1 tolerance; csr_ready is always high, writes belong
// only where the pipeline is empty and no result is waiting.
// throughput: one pair per cycle while no stalled result holds the term stage;
// a pair passes the input, product and term registers, then the accumulator
// loads the result register from the last term of a vector.
// the accumulator state is the only feedback path and each term updates it as
// it is taken, so pairs stream without gaps.
// reset empties the pipeline, clears the accumulator (all-close flag set) and both registers to zero.
// when the receiver stalls, the result waits in its register while further
// pairs keep flowing; only a second last pair held in the term stage waits,
// and the three stages then back up until req_ready drops.
module vector_reduction_unit_top import vru_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [31:0]          req_elem_a,
   input  logic signed [31:0]          req_elem_b,
   input  logic                        req_last_element,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [63:0]          rsp_value,
   output logic                        rsp_all_close,
   output logic                        rsp_overflowed,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   logic [MODE_WIDTH-1:0] mode_ff;
   logic [TOL_WIDTH-1:0]  tolerance_ff;
   logic [MODE_WIDTH-1:0] mode_in;
   logic [TOL_WIDTH-1:0]  tolerance_in;

   logic                 term_valid;
   logic                 term_ready;
   term_type             term;
   logic [ACC_WIDTH-1:0] value;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      mode_in      = mode_ff;
      tolerance_in = tolerance_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:      mode_in      = csr_data[MODE_WIDTH-1:0];
            CSR_TOLERANCE: tolerance_in = csr_data[TOL_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DOT;
         tolerance_ff <= {TOL_WIDTH{1'b0}};
      end else begin
         mode_ff      <= mode_in;
         tolerance_ff <= tolerance_in;
      end
   end

   // term pipeline
   vru_term u_term (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .elem_a    (req_elem_a),
      .elem_b    (req_elem_b),
      .last      (req_last_element),
      .mode      (mode_ff),
      .tolerance (tolerance_ff),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_term  (term)
   );

   // accumulator and result register
   vru_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .term_valid     (term_valid),
      .term_ready     (term_ready),
      .term           (term),
      .mode           (mode_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (value),
      .rsp_all_close  (rsp_all_close),
      .rsp_overflowed (rsp_overflowed)
   );

   assign rsp_value = $signed(value);

endmodule
